// ===== hw/rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

  // Width of the item and value ports
  localparam int unsigned ITEM_BITS = 32;

  // Command codes on in_cmd; codes above POP_BACK act as report only
  typedef enum logic [2:0] {
    CMD_REPORT     = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_t;

  // Status codes on out_status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_FROM_LEFT,
    OP_SHIFT_FROM_RIGHT,
    OP_LOAD_BACK,
    OP_DROP_BACK
  } cell_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdq_cell.sv =====
`default_nettype none

// One slot of the deque chain. Words sit packed from cell 0 (front) upward;
// each cell decides from its own valid bit and its neighbors' what to do.
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int unsigned DATA_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cell_op_t             op,
  input  wire logic [DATA_BITS-1:0] push_data,
  input  wire logic                 left_valid,
  input  wire logic [DATA_BITS-1:0] left_data,
  input  wire logic                 right_valid,
  input  wire logic [DATA_BITS-1:0] right_data,
  output logic                      valid_nxt,
  output logic      [DATA_BITS-1:0] data_nxt,
  output logic                      valid_r,
  output logic      [DATA_BITS-1:0] data_r
);

  // Next slot contents
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    unique case (op)
      OP_HOLD: begin
      end
      OP_SHIFT_FROM_LEFT: begin
        valid_nxt = left_valid;
        data_nxt  = left_data;
      end
      OP_SHIFT_FROM_RIGHT: begin
        valid_nxt = right_valid;
        data_nxt  = right_data;
      end
      OP_LOAD_BACK: begin
        // first empty slot takes the word
        if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          data_nxt  = push_data;
        end
      end
      OP_DROP_BACK: begin
        // last occupied slot lets go
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque.sv =====
`default_nettype none

// Double-ended queue of CAPACITY words. Each accepted command (report, push
// front, push back, pop front, pop back) produces exactly one result that
// carries the status, the front and rear words (zero when empty), the count
// and the empty/full flags as they stand after the command. Storage is a row
// of CAPACITY cells with front at cell 0; pushes and pops at the front shift
// the whole row by one slot; a back push fills only the first empty cell and
// a back pop clears only the last occupied cell. A command is taken every
// cycle while in_stall is low, and its result appears in the output register
// in the next cycle; in_stall only rises while that register holds an untaken
// result and out_stall is high. Pushing into a full deque reports overflow,
// popping an empty one reports underflow, and neither changes the contents.
// Words are kept in their low WORD_BITS bits (up to 32), returned zero-extended.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [2:0]                   in_cmd,
  input  wire logic signed [ITEM_BITS-1:0]         in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [1:0]                   out_status,
  output logic signed      [ITEM_BITS-1:0]         out_front_value,
  output logic signed      [ITEM_BITS-1:0]         out_rear_value,
  output logic             [$clog2(CAPACITY+1)-1:0] out_occupancy_out,
  output logic                                     out_is_empty,
  output logic                                     out_is_full
);

  localparam int unsigned CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int unsigned CELL_BITS = (WORD_BITS < ITEM_BITS) ? WORD_BITS : ITEM_BITS;

  logic                 accept;
  cell_op_t             op;
  status_t              status;
  logic [CNT_BITS-1:0]  occ_r;
  logic [CNT_BITS-1:0]  occ_nxt;
  logic [CELL_BITS-1:0] push_word;

  logic [CAPACITY-1:0]  valid_r;
  logic [CAPACITY-1:0]  valid_nxt;
  logic [CAPACITY-1:0]  last_nxt;
  logic [CELL_BITS-1:0] data_r   [CAPACITY];
  logic [CELL_BITS-1:0] data_nxt [CAPACITY];

  logic [CELL_BITS-1:0] rear_word;
  logic [ITEM_BITS-1:0] front_ext;
  logic [ITEM_BITS-1:0] rear_ext;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  status_t              out_status_r;
  logic [ITEM_BITS-1:0] out_front_r;
  logic [ITEM_BITS-1:0] out_rear_r;
  logic [CNT_BITS-1:0]  out_occ_r;
  logic                 out_empty_r;
  logic                 out_full_r;

  logic                 full;
  logic                 empty;

  // Handshake: the output register decouples the two sides
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = valid_r[CAPACITY-1];
  assign empty    = !valid_r[0];
  assign push_word = in_item[CELL_BITS-1:0];

  // Command decode into one chain operation
  always_comb begin
    op      = OP_HOLD;
    status  = ST_OK;
    occ_nxt = occ_r;
    if (accept) begin
      unique case (in_cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            status = ST_OVERFLOW;
          end else begin
            op      = (in_cmd == CMD_PUSH_FRONT) ? OP_SHIFT_FROM_LEFT : OP_LOAD_BACK;
            occ_nxt = occ_r + CNT_BITS'(1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty) begin
            status = ST_UNDERFLOW;
          end else begin
            op      = (in_cmd == CMD_POP_FRONT) ? OP_SHIFT_FROM_RIGHT : OP_DROP_BACK;
            occ_nxt = occ_r - CNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Chain of cells; cell 0 sees the pushed word as its left neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 lv;
    logic [CELL_BITS-1:0] ld;
    logic                 rv;
    logic [CELL_BITS-1:0] rd;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = push_word;
    end else begin : g_mid_l
      assign lv = valid_r[i-1];
      assign ld = data_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv          = 1'b0;
      assign rd          = '0;
      assign last_nxt[i] = valid_nxt[i];
    end else begin : g_mid_r
      assign rv          = valid_r[i+1];
      assign rd          = data_r[i+1];
      assign last_nxt[i] = valid_nxt[i] && !valid_nxt[i+1];
    end

    cdq_cell #(
      .DATA_BITS (CELL_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .push_data   (push_word),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid_nxt   (valid_nxt[i]),
      .data_nxt    (data_nxt[i]),
      .valid_r     (valid_r[i]),
      .data_r      (data_r[i])
    );
  end

  // Rear word: one-hot select of the last occupied cell
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rear_word = rear_word | (data_nxt[i] & {CELL_BITS{last_nxt[i]}});
    end
  end

  // Zero-extend stored words to port width; zero when empty
  always_comb begin
    front_ext = '0;
    rear_ext  = '0;
    if (valid_nxt[0]) begin
      front_ext[CELL_BITS-1:0] = data_nxt[0];
      rear_ext[CELL_BITS-1:0]  = rear_word;
    end
  end

  // Output register valid
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on every transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_front_r  <= front_ext;
      out_rear_r   <= rear_ext;
      out_occ_r    <= occ_nxt;
      out_empty_r  <= !valid_nxt[0];
      out_full_r   <= valid_nxt[CAPACITY-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_front_value   = out_front_r;
  assign out_rear_value    = out_rear_r;
  assign out_occupancy_out = out_occ_r;
  assign out_is_empty      = out_empty_r;
  assign out_is_full       = out_full_r;

  // Count register agrees with the occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r))
    else $error("occupancy count differs from occupied cells");

  // Occupied cells stay packed toward the front
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_r >> 1) & ~valid_r) == '0)
    else $error("hole in the cell chain");

  // A rejected push leaves the count alone
  a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK))
    |=> $stable(occ_r))
    else $error("overflowing push changed the count");

  // An empty result reports zero words
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_front_r == '0 && out_rear_r == '0))
    else $error("empty result carries nonzero words");

endmodule

`default_nettype wire

// ===== tb/tb_circular_deque.sv =====
module tb_circular_deque;
  import cdq_pkg::*;

  localparam int unsigned CAP        = 16;
  localparam int unsigned N_ITEMS    = 1050;
  localparam int unsigned PHASE_LEN  = 350;

  // One command waiting to be sent; drain_first holds it back until all
  // earlier results have come out
  typedef struct packed {
    logic [2:0]           cmd;
    logic [ITEM_BITS-1:0] word;
    bit                   drain_first;
  } deque_cmd_t;

  // What the deque reports after one command
  typedef struct packed {
    status_t              status;
    logic [ITEM_BITS-1:0] front;
    logic [ITEM_BITS-1:0] rear;
    logic [4:0]           count;
    logic                 empty;
    logic                 full;
  } deque_view_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [2:0]                  in_cmd = '0;
  logic signed [ITEM_BITS-1:0] in_item = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_status;
  logic signed [ITEM_BITS-1:0] out_front_value;
  logic signed [ITEM_BITS-1:0] out_rear_value;
  logic [4:0]                  out_occupancy_out;
  logic                        out_is_empty;
  logic                        out_is_full;

  deque_cmd_t  cmd_backlog[$];
  deque_view_t expected_views[$];
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned fail_count = 0;

  // Shadow copy of the deque contents
  logic [ITEM_BITS-1:0] shadow_ring [CAP];
  logic [3:0]           shadow_head = '0;
  logic [3:0]           shadow_tail = '0;
  logic [4:0]           shadow_count = '0;

  circular_deque #(
    .CAPACITY (CAP),
    .WORD_BITS(ITEM_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_occupancy_out(out_occupancy_out),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the shadow deque and return the view it leaves
  function automatic deque_view_t deque_apply(input logic [2:0] cmd,
                                              input logic [ITEM_BITS-1:0] word);
    deque_view_t v;
    v = '0;
    v.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_count == CAP) begin
          v.status = ST_OVERFLOW;
        end else if (cmd == CMD_PUSH_FRONT) begin
          shadow_head = shadow_head - 4'd1;
          shadow_ring[shadow_head] = word;
          shadow_count = shadow_count + 5'd1;
        end else begin
          shadow_ring[shadow_tail] = word;
          shadow_tail = shadow_tail + 4'd1;
          shadow_count = shadow_count + 5'd1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          v.status = ST_UNDERFLOW;
        end else if (cmd == CMD_POP_FRONT) begin
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 5'd1;
        end else begin
          shadow_tail = shadow_tail - 4'd1;
          shadow_count = shadow_count - 5'd1;
        end
      end
      default: ;  // report only, unused codes included
    endcase
    if (shadow_count != 0) begin
      v.front = shadow_ring[shadow_head];
      v.rear  = shadow_ring[shadow_tail - 4'd1];
    end
    v.count = shadow_count;
    v.empty = (shadow_count == 0);
    v.full  = (shadow_count == CAP);
    return v;
  endfunction

  // Idle rates by phase: sender-light/receiver-heavy, then swapped, then none
  function automatic int unsigned idle_pct(input bit sender);
    if (n_sent < PHASE_LEN) return sender ? 14 : 88;
    if (n_sent < 2 * PHASE_LEN) return sender ? 88 : 14;
    return 0;
  endfunction

  function automatic logic [ITEM_BITS-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(input logic [2:0] cmd, input logic [ITEM_BITS-1:0] word,
                           input bit drain_first = 1'b0);
    cmd_backlog.push_back('{cmd: cmd, word: word, drain_first: drain_first});
  endtask

  // Driver: predict on each accepted transfer, then present the next command
  always @(posedge clk) begin : driver
    deque_cmd_t nxt;
    bit         took;
    bit         go;
    if (rst_n) begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_views.push_back(deque_apply(in_cmd, in_item));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || took) begin
        go = (cmd_backlog.size() != 0) && ($urandom_range(99) >= idle_pct(1'b1));
        if (go && cmd_backlog[0].drain_first && (n_sent + took != n_seen))
          go = 1'b0;
        if (go) begin
          nxt = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_cmd   <= nxt.cmd;
          in_item  <= nxt.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, check each result transfer in order
  always @(posedge clk) begin : monitor
    deque_view_t got;
    deque_view_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
      if (out_valid && !out_stall) begin
        got = '{status: status_t'(out_status), front: out_front_value,
                rear: out_rear_value, count: out_occupancy_out,
                empty: out_is_empty, full: out_is_full};
        n_seen <= n_seen + 1;
        if (expected_views.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result transfer: status %0d front %h rear %h count %0d",
                     got.status, got.front, got.rear, got.count);
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("mismatch on result %0d:", n_seen);
              $display("  status exp %0d got %0d, front exp %h got %h, rear exp %h got %h",
                       want.status, got.status, want.front, got.front,
                       want.rear, got.rear);
              $display("  count exp %0d got %0d, empty exp %b got %b, full exp %b got %b",
                       want.count, got.count, want.empty, got.empty,
                       want.full, got.full);
            end
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned n_queued;
    int unsigned burst;
    int unsigned mode;
    int unsigned roll;
    logic [2:0]  cmd;

    // Directed: underflow on empty, extremes, unused codes, fill and overflow
    queue_cmd(CMD_REPORT, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_POP_BACK, '1);
    queue_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff);
    queue_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    queue_cmd(3'd5, 32'h1234_5678);
    queue_cmd(3'd7, '1);
    queue_cmd(CMD_POP_BACK, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    for (int i = 0; i < CAP; i++)
      queue_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, i[1] ? '1 : $urandom);
    queue_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
    n_queued = cmd_backlog.size();

    // Random: bursts biased toward filling, draining or a free mix
    while (n_queued < N_ITEMS) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(8, 40);
      for (int i = 0; i < burst; i++) begin
        roll = $urandom_range(99);
        if (roll < 5)
          cmd = 3'($urandom_range(7));
        else if ((mode == 0 && roll < 80) || (mode == 1 && roll >= 80))
          cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (mode != 2)
          cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        else
          cmd = 3'($urandom_range(4));
        queue_cmd(cmd, pick_word(), n_queued == 300 || n_queued == 800);
        n_queued++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_deque.sv
tb/tb_circular_deque.sv
